/* sv/kli_pkg.sv */
// kli_pkg: shared types and constants of the keyframe linear interpolator
// no dependencies; imported by keyframe_linear_interpolator

package kli_pkg;

   // store geometry
   localparam int MAX_KEYFRAMES = 64;
   localparam int ADDR_W        = $clog2(MAX_KEYFRAMES);
   localparam int CNT_W         = $clog2(MAX_KEYFRAMES + 1);

   // field widths
   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 32;
   localparam int TIME_W   = 32;
   localparam int FRAC_W   = 16;
   localparam int POINT_W  = NUM_AXES * AXIS_W;

   // serial datapath widths
   localparam int PROD_W  = TIME_W + ADDR_W;
   localparam int DIFF_W  = AXIS_W + 1;
   localparam int LPROD_W = DIFF_W + FRAC_W;
   localparam int ITER_W  = $clog2(TIME_W + 1);

   // port widths
   localparam int REQ_DATA_W = TIME_W + POINT_W;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = POINT_W;
   localparam int RSP_USER_W = 1;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DURATION  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_MODE = 1'b1;

   localparam logic [TIME_W-1:0] DURATION_RESET = 32'h0001_0000;

   typedef logic [NUM_AXES-1:0][AXIS_W-1:0] point_type;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_MUL,
      ST_SEG,
      ST_FRAC,
      ST_RD_A,
      ST_RD_B,
      ST_DIFF,
      ST_LERP,
      ST_OUT
   } state_type;

endpackage

/* sv/keyframe_linear_interpolator.sv */
// keyframe_linear_interpolator: keyframe store and serial query engine
// depends on kli_pkg (constants, op codes, state type)

// Keeps up to MAX_KEYFRAMES (64) 3D points in signed Q16.16 and answers position
// queries by linear interpolation. The op code on req_tuser selects append (point
// written at the next free slot, dropped when the store is full), clear (count set
// to zero) or query. Append and clear give no response beat; op code 3 is ignored.
// A query reduces the time (modulo duration in loop mode, else clamped to duration),
// picks segment floor(t*(n-1)/duration) with a truncated Q0.16 fraction and returns
// a+((b-a)*frac)>>>16 per axis. A query on an empty store returns zeros with the
// empty flag set. One stored point or a zero duration skips the division. Otherwise
// a query works through one shared radix-2 divider that handles the wrap (loop
// mode only), the segment and the fraction in turn, a bit-serial multiply of time
// by n-1, two reads through the single read port of the keyframe memory and a
// bit-serial 16-step multiply of the three axis differences by the fraction. One
// query is worked on at a time; the result sits in an output register, so appends
// and clears keep flowing while a response beat waits for rsp_tready.

module keyframe_linear_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kli_pkg::REQ_DATA_W-1:0]      req_tdata,  // time_req, key_x, key_y, key_z
   input  logic [kli_pkg::REQ_USER_W-1:0]      req_tuser,  // op
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kli_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // pos_x, pos_y, pos_z
   output logic [kli_pkg::RSP_USER_W-1:0]      rsp_tuser,  // store_empty
   // configuration writes
   input  logic                                csr_we,
   input  logic [kli_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [kli_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import kli_pkg::*;

   // ---------------------------------------------------------------- registers
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TIME_W-1:0]        duration_ff;
   logic                     loop_ff;

   // divider / multiplier shift registers
   logic [TIME_W-1:0]        time_ff, time_in;      // reduced query time
   logic [TIME_W-1:0]        rem_ff, rem_in;        // partial remainder
   logic [TIME_W-1:0]        qd_ff, qd_in;          // dividend in, quotient out
   logic [PROD_W-1:0]        acc_ff, acc_in;        // t * (n-1)
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic [ADDR_W-1:0]        last_ff, last_in;
   logic [ADDR_W-1:0]        seg_ff, seg_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic                     empty_ff, empty_in;

   // interpolation lanes, one per axis
   point_type                a_ff, a_in;
   logic [NUM_AXES-1:0][DIFF_W-1:0]  diff_ff, diff_in;
   logic [NUM_AXES-1:0][LPROD_W-1:0] lacc_ff, lacc_in;

   // keyframe memory, single read port with registered data
   point_type                mem_ff [MAX_KEYFRAMES];
   point_type                rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     mem_we;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   point_type                rsp_data_ff, rsp_data_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   // ------------------------------------------------------------ request side
   logic                     req_accept;
   op_type                   req_op;
   logic [TIME_W-1:0]        req_time;
   point_type                req_point;
   logic [ADDR_W-1:0]        count_m1;
   logic [TIME_W-1:0]        time_clamp;
   logic                     store_full;
   logic                     out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_time   = req_tdata[TIME_W-1:0];
   assign req_point  = req_tdata[TIME_W +: POINT_W];
   assign count_m1   = ADDR_W'(count_ff - CNT_W'(1));
   assign time_clamp = (req_time > duration_ff) ? duration_ff : req_time;
   assign store_full = (count_ff == CNT_W'(MAX_KEYFRAMES));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mem_we     = req_accept && (req_op == OP_APPEND) && !store_full;

   // ------------------------------------------------------ shared radix-2 step
   // restoring step: remainder stays below duration, so 33 bits suffice
   logic [TIME_W:0]          div_shift;
   logic                     div_ge;
   logic [TIME_W-1:0]        div_rem;
   logic [TIME_W-1:0]        div_qd;
   logic                     iter_last;
   logic [PROD_W-1:0]        mul_sum;

   assign div_shift = {rem_ff, qd_ff[TIME_W-1]};
   assign div_ge    = div_shift >= {1'b0, duration_ff};
   assign div_rem   = div_ge ? (div_shift[TIME_W-1:0] - duration_ff) : div_shift[TIME_W-1:0];
   assign div_qd    = {qd_ff[TIME_W-2:0], div_ge};
   assign iter_last = (iter_ff == ITER_W'(1));

   // multiplier bits of n-1 come out of qd_ff, msb first
   assign mul_sum = {acc_ff[PROD_W-2:0], 1'b0}
                  + (qd_ff[TIME_W-1] ? {{ADDR_W{1'b0}}, time_ff} : '0);

   // ---------------------------------------------------------- lane arithmetic
   logic [NUM_AXES-1:0][DIFF_W-1:0]  diff_calc;
   logic [NUM_AXES-1:0][LPROD_W-1:0] lerp_step;
   point_type                        pos_calc;

   always_comb begin
      for (int k = 0; k < NUM_AXES; k++) begin
         // b - a, sign extended so it cannot overflow
         diff_calc[k] = {rd_data_ff[k][AXIS_W-1], rd_data_ff[k]}
                      - {a_ff[k][AXIS_W-1], a_ff[k]};
         // signed shift-add over the fraction bits, msb first
         lerp_step[k] = {lacc_ff[k][LPROD_W-2:0], 1'b0}
                      + (frac_ff[FRAC_W-1] ? {{FRAC_W{diff_ff[k][DIFF_W-1]}}, diff_ff[k]}
                                           : '0);
         // floor of the product over 2^16 is its upper bits
         pos_calc[k]  = a_ff[k] + lacc_ff[k][FRAC_W +: AXIS_W];
      end
   end

   // second read takes the next point, or the last one again on the final segment
   assign rd_addr = (state_ff == ST_RD_B)
                  ? ((seg_ff == last_ff) ? seg_ff : seg_ff + ADDR_W'(1))
                  : seg_ff;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_op == OP_QUERY)) begin
               priority if (count_ff == '0)                                state_in = ST_OUT;
               else if (count_ff == CNT_W'(1) || duration_ff == '0)       state_in = ST_RD_A;
               else if (loop_ff)                                          state_in = ST_MOD;
               else                                                       state_in = ST_MUL;
            end
         end
         ST_MOD:  if (iter_last) state_in = ST_MUL;
         ST_MUL:  if (iter_last) state_in = ST_SEG;
         ST_SEG:  if (iter_last) state_in = ST_FRAC;
         ST_FRAC: if (iter_last) state_in = ST_RD_A;
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_LERP;
         ST_LERP: if (iter_last) state_in = ST_OUT;
         ST_OUT:  if (out_free)  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------ datapath
   always_comb begin
      count_in     = count_ff;
      time_in      = time_ff;
      rem_in       = rem_ff;
      qd_in        = qd_ff;
      acc_in       = acc_ff;
      iter_in      = iter_ff;
      last_in      = last_ff;
      seg_in       = seg_ff;
      frac_in      = frac_ff;
      empty_in     = empty_ff;
      a_in         = a_ff;
      diff_in      = diff_ff;
      lacc_in      = lacc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_op)
                  OP_APPEND: if (!store_full) count_in = count_ff + CNT_W'(1);
                  OP_CLEAR:  count_in = '0;
                  OP_QUERY: begin
                     empty_in = (count_ff == '0);
                     last_in  = count_m1;
                     // short path (one point or zero duration) uses segment 0, fraction 0
                     seg_in   = '0;
                     frac_in  = '0;
                     if (loop_ff) begin
                        time_in = req_time;
                        rem_in  = '0;
                        qd_in   = req_time;
                        iter_in = ITER_W'(TIME_W);
                     end else begin
                        time_in = time_clamp;
                        qd_in   = {count_m1, {(TIME_W-ADDR_W){1'b0}}};
                        acc_in  = '0;
                        iter_in = ITER_W'(ADDR_W);
                     end
                  end
                  default: ;  // unused op code
               endcase
            end
         end
         ST_MOD: begin
            // time modulo duration
            rem_in  = div_rem;
            qd_in   = div_qd;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_last) begin
               time_in = div_rem;
               qd_in   = {last_ff, {(TIME_W-ADDR_W){1'b0}}};
               acc_in  = '0;
               iter_in = ITER_W'(ADDR_W);
            end
         end
         ST_MUL: begin
            acc_in  = mul_sum;
            qd_in   = {qd_ff[TIME_W-2:0], 1'b0};
            iter_in = iter_ff - ITER_W'(1);
            if (iter_last) begin
               // upper part is already below duration, so only ADDR_W quotient bits
               rem_in  = mul_sum[PROD_W-1:ADDR_W];
               qd_in   = {mul_sum[ADDR_W-1:0], {(TIME_W-ADDR_W){1'b0}}};
               iter_in = ITER_W'(ADDR_W);
            end
         end
         ST_SEG: begin
            rem_in  = div_rem;
            qd_in   = div_qd;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_last) begin
               seg_in  = div_qd[ADDR_W-1:0];
               qd_in   = '0;
               iter_in = ITER_W'(FRAC_W);
            end
         end
         ST_FRAC: begin
            // (remainder << 16) / duration
            rem_in  = div_rem;
            qd_in   = div_qd;
            iter_in = iter_ff - ITER_W'(1);
            if (iter_last) frac_in = div_qd[FRAC_W-1:0];
         end
         ST_RD_A: ;
         ST_RD_B: a_in = rd_data_ff;
         ST_DIFF: begin
            diff_in = diff_calc;
            lacc_in = '0;
            iter_in = ITER_W'(FRAC_W);
         end
         ST_LERP: begin
            lacc_in = lerp_step;
            frac_in = {frac_ff[FRAC_W-2:0], 1'b0};
            iter_in = iter_ff - ITER_W'(1);
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = empty_ff;
               rsp_data_in  = empty_ff ? '0 : pos_calc;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         duration_ff  <= DURATION_RESET;
         loop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_DURATION:  duration_ff <= csr_wdata[TIME_W-1:0];
               CSR_LOOP_MODE: loop_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      time_ff      <= time_in;
      rem_ff       <= rem_in;
      qd_ff        <= qd_in;
      acc_ff       <= acc_in;
      iter_ff      <= iter_in;
      last_ff      <= last_in;
      seg_ff       <= seg_in;
      frac_ff      <= frac_in;
      empty_ff     <= empty_in;
      a_ff         <= a_in;
      diff_ff      <= diff_in;
      lacc_ff      <= lacc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // ------------------------------------------------------------ keyframe store
   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[count_ff[ADDR_W-1:0]] <= req_point;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   // ------------------------------------------------------------------- outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEYFRAMES))
      else $error("keyframe count beyond store depth");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_APPEND) && store_full |=> store_full)
      else $error("append to a full store changed the count");

   a_empty_path: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_op == OP_QUERY) && (count_ff == '0) |=> state_ff == ST_OUT)
      else $error("empty-store query did not go straight to output");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD_A |-> seg_ff <= last_ff)
      else $error("segment index beyond last keyframe");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("empty response carries a nonzero position");

endmodule
